// File: src/assert_macros.svh
// Assertion helpers for the height-to-grayscale block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/hgr_pkg.sv
// ----------------------------------------------------------------------------
// hgr_pkg
// Types and constants shared by the height-to-grayscale controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package hgr_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    localparam int SAMPLE_W  = 32;   // Q16.16 sample and level width
    localparam int SIZE_W    = 13;   // width / height register width
    localparam int SHIFT_W   = 12;   // column shift register width
    localparam int INDEX_W   = 24;
    localparam int VALUE_W   = 16;
    localparam int CFG_IDX_W = 4;
    localparam int SIZE_CAP  = (1 << SIZE_W) - 1;

    localparam int FULL_8  = 255;
    localparam int FULL_16 = 65535;

    // one quotient bit per divider step
    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 4'd0,
        REG_HEIGHT = 4'd1,
        REG_DEPTH  = 4'd2,
        REG_FLIPC  = 4'd3,
        REG_FLIPR  = 4'd4,
        REG_SHIFT  = 4'd5,
        REG_MIN    = 4'd6,
        REG_MAX    = 4'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        VAL_QUOT,
        VAL_ZERO,
        VAL_FULL
    } val_sel_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [STEP_W-1:0] step_idx;
        logic              map;
        logic              emit;
    } hgr_cmd_t;

    typedef struct packed {
        logic out_free;
    } hgr_status_t;

endpackage

// File: src/hgr_ctrl.sv
// ----------------------------------------------------------------------------
// hgr_ctrl
// Sequencer: accept a sample, run the divider steps, map the address, then
// hand the result to the output register when it is free.
// ----------------------------------------------------------------------------
module hgr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  hgr_pkg::hgr_status_t status,
    output hgr_pkg::hgr_cmd_t   cmd
);

    hgr_pkg::ctrl_state_t            state_reg, state_next;
    logic [hgr_pkg::STEP_W-1:0]      step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hgr_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.step_idx = step_reg;
        case (state_reg)
            hgr_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = hgr_pkg::ST_DIV;
                end
            end
            hgr_pkg::ST_DIV: begin
                cmd.step = 1'b1;
                if (step_reg == hgr_pkg::STEP_W'(hgr_pkg::DIV_STEPS - 1)) begin
                    state_next = hgr_pkg::ST_MAP;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            hgr_pkg::ST_MAP: begin
                cmd.map    = 1'b1;
                state_next = hgr_pkg::ST_EMIT;
            end
            hgr_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = hgr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/hgr_datapath.sv
// ----------------------------------------------------------------------------
// hgr_datapath
// Configuration registers, raster counters, restoring divider for the gray
// level, shift reduction, destination address and output register.
// ----------------------------------------------------------------------------
module hgr_datapath #(
    parameter int MAX_WIDTH  = hgr_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = hgr_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [hgr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic [hgr_pkg::SAMPLE_W-1:0]       sample,
    input  hgr_pkg::hgr_cmd_t                  cmd,
    output hgr_pkg::hgr_status_t               status,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [hgr_pkg::INDEX_W-1:0]        pixel_index,
    output logic [hgr_pkg::VALUE_W-1:0]        pixel_value,
    output logic                               last_pixel
);

    localparam int SW    = hgr_pkg::SIZE_W;
    localparam int HW    = hgr_pkg::SHIFT_W;
    localparam int WCAP  = (MAX_WIDTH  < hgr_pkg::SIZE_CAP) ? MAX_WIDTH  : hgr_pkg::SIZE_CAP;
    localparam int HCAP  = (MAX_HEIGHT < hgr_pkg::SIZE_CAP) ? MAX_HEIGHT : hgr_pkg::SIZE_CAP;
    localparam int CNT_W = $clog2(WCAP);
    localparam int ROW_W = $clog2(HCAP);
    localparam int MW    = SW + HW;
    localparam int STEP_W_L = hgr_pkg::STEP_W;

    // configuration
    logic [SW-1:0]        width_cfg_reg, height_cfg_reg;
    logic                 depth_reg, flipc_reg, flipr_reg;
    logic [HW-1:0]        shift_cfg_reg;
    logic [31:0]          min_reg, max_reg;

    // raster counters and per-item control
    logic [CNT_W-1:0]     col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0]     row_cnt_reg, row_cnt_next;
    logic                 out_valid_reg;

    // per-item payload
    logic [CNT_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 last_reg;
    hgr_pkg::val_sel_t    sel_reg;
    logic [31:0]          r_reg, rem_reg;
    logic [15:0]          nlo_reg, quo_reg;
    logic [HW-1:0]        sm_reg;
    logic [hgr_pkg::INDEX_W-1:0] prod_reg;
    logic [SW-1:0]        x_reg;
    logic [hgr_pkg::VALUE_W-1:0] val_reg;
    logic [hgr_pkg::INDEX_W-1:0] out_index_reg;
    logic [hgr_pkg::VALUE_W-1:0] out_value_reg;
    logic                 out_last_reg;

    logic [SW-1:0]        w_eff, h_eff, col_cl, row_cl, col_ext, row_ext;
    logic signed [32:0]   d_s, r_s;
    logic                 d_pos, r_pos, d_ge_r;
    logic [47:0]          num;
    hgr_pkg::val_sel_t    sel_load;
    logic [32:0]          trial_div;
    logic [STEP_W_L-1:0]  bit_pos;
    logic [MW-1:0]        trial_mod;
    logic [SW:0]          x_sum;
    logic [SW-1:0]        x_wrap, x_dst, y_dst;
    logic [2*SW-1:0]      prod;
    logic [hgr_pkg::VALUE_W-1:0] full_val;

    // effective image size: zero reads as one, large values saturate
    always_comb begin
        if (width_cfg_reg == '0)
            w_eff = SW'(1);
        else if (32'(width_cfg_reg) > 32'(WCAP))
            w_eff = SW'(WCAP);
        else
            w_eff = width_cfg_reg;
        if (height_cfg_reg == '0)
            h_eff = SW'(1);
        else if (32'(height_cfg_reg) > 32'(HCAP))
            h_eff = SW'(HCAP);
        else
            h_eff = height_cfg_reg;
    end

    assign col_ext = SW'(col_cnt_reg);
    assign row_ext = SW'(row_cnt_reg);
    assign col_cl  = (col_ext >= w_eff) ? (w_eff - 1'b1) : col_ext;
    assign row_cl  = (row_ext >= h_eff) ? (h_eff - 1'b1) : row_ext;

    // level arithmetic on the incoming sample
    assign d_s    = {sample[31], sample} - {min_reg[31], min_reg};
    assign r_s    = {max_reg[31], max_reg} - {min_reg[31], min_reg};
    assign d_pos  = !d_s[32] && (d_s != '0);
    assign r_pos  = !r_s[32] && (r_s != '0);
    assign d_ge_r = d_s[31:0] >= r_s[31:0];
    // d * full as a shift and subtract
    assign num = depth_reg ? ({d_s[31:0], 16'd0} - {16'd0, d_s[31:0]})
                           : ({8'd0, d_s[31:0], 8'd0} - {16'd0, d_s[31:0]});

    always_comb begin
        if (!r_pos)
            sel_load = hgr_pkg::VAL_FULL;
        else if (!d_pos)
            sel_load = hgr_pkg::VAL_ZERO;
        else if (d_ge_r)
            sel_load = hgr_pkg::VAL_FULL;
        else
            sel_load = hgr_pkg::VAL_QUOT;
    end

    // d < r here, so the quotient fits in 16 bits and num >> 16 starts below r
    assign trial_div = {rem_reg, nlo_reg[15]};
    assign bit_pos   = STEP_W_L'(HW - 1) - cmd.step_idx;
    assign trial_mod = MW'(w_eff) << bit_pos;

    // destination address
    assign x_sum  = {1'b0, SW'(col_reg)} + {1'b0, SW'(sm_reg)};
    assign x_wrap = (x_sum >= {1'b0, w_eff}) ? SW'(x_sum - {1'b0, w_eff}) : x_sum[SW-1:0];
    assign x_dst  = flipc_reg ? (w_eff - 1'b1 - x_wrap) : x_wrap;
    assign y_dst  = flipr_reg ? (h_eff - 1'b1 - SW'(row_reg)) : SW'(row_reg);
    assign prod   = y_dst * w_eff;

    assign full_val = depth_reg ? hgr_pkg::VALUE_W'(hgr_pkg::FULL_16)
                                : hgr_pkg::VALUE_W'(hgr_pkg::FULL_8);

    // raster advance after the current pixel
    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cmd.emit) begin
            if (SW'(col_reg) + 1'b1 >= w_eff) begin
                col_cnt_next = '0;
                row_cnt_next = (SW'(row_reg) + 1'b1 >= h_eff) ? '0 : row_reg + 1'b1;
            end else begin
                col_cnt_next = col_reg + 1'b1;
                row_cnt_next = row_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= SW'(1);
            height_cfg_reg <= SW'(1);
            depth_reg      <= 1'b0;
            flipc_reg      <= 1'b0;
            flipr_reg      <= 1'b0;
            shift_cfg_reg  <= '0;
            min_reg        <= 32'd0;
            max_reg        <= 32'd65536;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    hgr_pkg::REG_WIDTH:  width_cfg_reg  <= cfg_data[SW-1:0];
                    hgr_pkg::REG_HEIGHT: height_cfg_reg <= cfg_data[SW-1:0];
                    hgr_pkg::REG_DEPTH:  depth_reg      <= cfg_data[0];
                    hgr_pkg::REG_FLIPC:  flipc_reg      <= cfg_data[0];
                    hgr_pkg::REG_FLIPR:  flipr_reg      <= cfg_data[0];
                    hgr_pkg::REG_SHIFT:  shift_cfg_reg  <= cfg_data[HW-1:0];
                    hgr_pkg::REG_MIN:    min_reg        <= cfg_data;
                    hgr_pkg::REG_MAX:    max_reg        <= cfg_data;
                    default: ;
                endcase
            end
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg  <= col_cl[CNT_W-1:0];
            row_reg  <= row_cl[ROW_W-1:0];
            last_reg <= (col_cl == w_eff - 1'b1) && (row_cl == h_eff - 1'b1);
            sel_reg  <= sel_load;
            r_reg    <= r_s[31:0];
            rem_reg  <= num[47:16];
            nlo_reg  <= num[15:0];
            quo_reg  <= '0;
            sm_reg   <= shift_cfg_reg;
        end
        if (cmd.step) begin
            nlo_reg <= {nlo_reg[14:0], 1'b0};
            if (trial_div >= {1'b0, r_reg}) begin
                rem_reg <= 32'(trial_div - {1'b0, r_reg});
                quo_reg <= {quo_reg[14:0], 1'b1};
            end else begin
                rem_reg <= trial_div[31:0];
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
            // restoring reduction of the shift modulo the width, high bit first
            if (cmd.step_idx < STEP_W_L'(HW) && MW'(sm_reg) >= trial_mod)
                sm_reg <= sm_reg - trial_mod[HW-1:0];
        end
        if (cmd.map) begin
            prod_reg <= prod[hgr_pkg::INDEX_W-1:0];
            x_reg    <= x_dst;
            case (sel_reg)
                hgr_pkg::VAL_FULL: val_reg <= full_val;
                hgr_pkg::VAL_ZERO: val_reg <= '0;
                default:           val_reg <= quo_reg;
            endcase
        end
        if (cmd.emit) begin
            out_index_reg <= prod_reg + hgr_pkg::INDEX_W'(x_reg);
            out_value_reg <= val_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign pixel_index     = out_index_reg;
    assign pixel_value     = out_value_reg;
    assign last_pixel      = out_last_reg;

endmodule

// File: src/heightmap_to_grayscale_raster.sv
// Height samples enter in raster order, one beat per pixel, and each yields one
// output beat carrying the destination index, the gray level and a last-pixel
// flag. From accept a pixel passes through 16 steps of the restoring divider
// (one quotient bit per cycle, the shift reduction runs in the same steps),
// the address multiply and the load of the output register, which waits until
// that register is free; a new sample is taken only after that load. The output
// register lets the next sample in while a finished pixel still waits. The
// configuration port is always ready; write it only between images, with no
// pixel in flight.
// ----------------------------------------------------------------------------
// heightmap_to_grayscale_raster
// Min-max normalization of a Q16.16 height raster to 8- or 16-bit grayscale
// with column rotation and optional flips.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heightmap_to_grayscale_raster #(
    parameter int MAX_WIDTH  = hgr_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = hgr_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hgr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // [31:0] height_sample
    // pixel stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [23:0] pixel_index, [39:24] pixel_value
    output logic                          m_tlast    // last_pixel
);

    hgr_pkg::hgr_cmd_t           cmd;
    hgr_pkg::hgr_status_t        status;
    logic [hgr_pkg::INDEX_W-1:0] pixel_index;
    logic [hgr_pkg::VALUE_W-1:0] pixel_value;

    assign cfg_ready = 1'b1;

    hgr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hgr_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .pixel_index (pixel_index),
        .pixel_value (pixel_value),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {pixel_value, pixel_index};

    // one sample in flight: no accept right after an accept
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // the output register is only loaded when it is empty or draining
    `ASSERT_IMPL(a_emit_when_free, aclk, aresetn, cmd.emit, !m_tvalid || m_tready)
    // a loaded result is presented on the next cycle
    `ASSERT_NEXT(a_emit_shows, aclk, aresetn, cmd.emit, m_tvalid)

endmodule
